// File: design/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, widths and helpers shared by the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int NORMAL_WIDTH = 16;

  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int RED_W   = 31;
  localparam int SHIFT_W = $clog2(MAG_W + 1);
  localparam int SQ_W    = 2 * RED_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int NUM_W   = RED_W + NORMAL_WIDTH + 1;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int QUO_W   = NORMAL_WIDTH;
  localparam int TRY_W   = DEN_W + QUO_W;

  localparam logic [QUO_W-1:0] QMAX = QUO_W'((1 << (NORMAL_WIDTH - 1)) - 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
  } tri_word_t;

  typedef struct packed {
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic                           degenerate;
  } norm_word_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] x;
    logic signed [CROSS_W-1:0] y;
    logic signed [CROSS_W-1:0] z;
  } cross_t;

  // reduced magnitudes and signs that ride along with the root/divide
  typedef struct packed {
    logic [2:0][RED_W-1:0] red;
    logic [2:0]            neg;
    logic                  degen;
  } lane_t;

  function automatic logic [SHIFT_W-1:0] bit_len(input logic [MAG_W-1:0] v);
    logic [SHIFT_W-1:0] len;
    len = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) len = SHIFT_W'(i + 1);
    end
    return len;
  endfunction

endpackage

// File: design/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors and exact cross product, three register stages.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  tri_word_t in_word,
  output logic      out_valid,
  output cross_t    out_cross
);

  logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PROD_W-1:0] pax, pbx, pay, pby, paz, pbz;
  logic                     v1, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= EDGE_W'(in_word.vertex_b_x) - EDGE_W'(in_word.vertex_a_x);
      e1y <= EDGE_W'(in_word.vertex_b_y) - EDGE_W'(in_word.vertex_a_y);
      e1z <= EDGE_W'(in_word.vertex_b_z) - EDGE_W'(in_word.vertex_a_z);
      e2x <= EDGE_W'(in_word.vertex_c_x) - EDGE_W'(in_word.vertex_a_x);
      e2y <= EDGE_W'(in_word.vertex_c_y) - EDGE_W'(in_word.vertex_a_y);
      e2z <= EDGE_W'(in_word.vertex_c_z) - EDGE_W'(in_word.vertex_a_z);
      pax <= e1y * e2z;
      pbx <= e1z * e2y;
      pay <= e1z * e2x;
      pby <= e1x * e2z;
      paz <= e1x * e2y;
      pbz <= e1y * e2x;
      out_cross.x <= CROSS_W'(pax) - CROSS_W'(pbx);
      out_cross.y <= CROSS_W'(pay) - CROSS_W'(pby);
      out_cross.z <= CROSS_W'(paz) - CROSS_W'(pbz);
    end
  end

endmodule

// File: design/tfn_scale.sv
// ----------------------------------------------------------------------------
// tfn_scale
// Magnitudes, reduction to 31 bits, squares and their sum, four stages.
// ----------------------------------------------------------------------------
module tfn_scale import tfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  cross_t           in_cross,
  output logic             out_valid,
  output logic [SUM_W-1:0] out_sum,
  output lane_t            out_lane
);

  logic [2:0][MAG_W-1:0] mag;
  logic [2:0]            mag_neg;
  lane_t                 lane5, lane6;
  logic [2:0][SQ_W-1:0]  sq;
  logic                  v4, v5, v6;

  logic [MAG_W-1:0]   mag_or;
  logic [SHIFT_W-1:0] len, sh;
  lane_t              lane_next;

  always_comb begin
    mag_or = mag[0] | mag[1] | mag[2];
    len    = bit_len(mag_or);
    sh     = (len > SHIFT_W'(RED_W)) ? len - SHIFT_W'(RED_W) : '0;
    for (int i = 0; i < 3; i++) begin
      lane_next.red[i] = RED_W'(mag[i] >> sh);
    end
    lane_next.neg   = mag_neg;
    lane_next.degen = (mag_or == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_neg[0] <= in_cross.x[CROSS_W-1];
      mag_neg[1] <= in_cross.y[CROSS_W-1];
      mag_neg[2] <= in_cross.z[CROSS_W-1];
      mag[0] <= in_cross.x[CROSS_W-1] ? MAG_W'(-in_cross.x) : MAG_W'(in_cross.x);
      mag[1] <= in_cross.y[CROSS_W-1] ? MAG_W'(-in_cross.y) : MAG_W'(in_cross.y);
      mag[2] <= in_cross.z[CROSS_W-1] ? MAG_W'(-in_cross.z) : MAG_W'(in_cross.z);
      lane5  <= lane_next;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(lane5.red[i]) * SQ_W'(lane5.red[i]);
      end
      lane6    <= lane5;
      out_sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      out_lane <= lane6;
    end
  end

endmodule

// File: design/tfn_isqrt.sv
// ----------------------------------------------------------------------------
// tfn_isqrt
// Integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module tfn_isqrt import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  lane_t             in_lane,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output lane_t             out_lane
);

  localparam int TW = SUM_W + 2;

  logic [SUM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  lane_t             lane [ROOT_W];
  logic              vld  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    lane_t             lane_in;
    logic              vld_in;
    logic [TW-1:0]     trial;

    if (j == 0) begin : g_first
      always_comb begin
        rem_in  = in_sum;
        root_in = '0;
        lane_in = in_lane;
        vld_in  = in_valid;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem[j-1];
        root_in = root[j-1];
        lane_in = lane[j-1];
        vld_in  = vld[j-1];
      end
    end

    // remainder minus (2*root + 2^K) * 2^K
    assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane[j] <= lane_in;
        if (TW'(rem_in) >= trial) begin
          rem[j]  <= SUM_W'(TW'(rem_in) - trial);
          root[j] <= root_in | (ROOT_W'(1) << K);
        end else begin
          rem[j]  <= rem_in;
          root[j] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_lane  = lane[ROOT_W-1];

endmodule

// File: design/tfn_div.sv
// ----------------------------------------------------------------------------
// tfn_div
// Rounded division of each reduced component by the norm, restoring
// divider with one quotient bit per stage, then saturate and sign.
// ----------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] in_root,
  input  lane_t             in_lane,
  output logic              out_valid,
  output norm_word_t        out_word
);

  logic [2:0][NUM_W-1:0] num0;
  logic [DEN_W-1:0]      den0;
  lane_t                 lane0;
  logic                  vld0;

  logic [2:0][NUM_W-1:0] rem  [QUO_W];
  logic [2:0][QUO_W-1:0] quo  [QUO_W];
  logic [DEN_W-1:0]      den  [QUO_W];
  lane_t                 lane [QUO_W];
  logic                  vld  [QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num0[i] <= (NUM_W'(in_lane.red[i]) << NORMAL_WIDTH) + NUM_W'(in_root);
      end
      den0  <= DEN_W'(in_root) << 1;
      lane0 <= in_lane;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [DEN_W-1:0]      den_in;
    lane_t                 lane_in;
    logic                  vld_in;
    logic [TRY_W-1:0]      trial;

    if (j == 0) begin : g_first
      always_comb begin
        rem_in  = num0;
        quo_in  = '0;
        den_in  = den0;
        lane_in = lane0;
        vld_in  = vld0;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = rem[j-1];
        quo_in  = quo[j-1];
        den_in  = den[j-1];
        lane_in = lane[j-1];
        vld_in  = vld[j-1];
      end
    end

    assign trial = TRY_W'(den_in) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[j]  <= den_in;
        lane[j] <= lane_in;
        for (int i = 0; i < 3; i++) begin
          if (TRY_W'(rem_in[i]) >= trial) begin
            rem[j][i] <= NUM_W'(TRY_W'(rem_in[i]) - trial);
            quo[j][i] <= quo_in[i] | (QUO_W'(1) << K);
          end else begin
            rem[j][i] <= rem_in[i];
            quo[j][i] <= quo_in[i];
          end
        end
      end
    end
  end

  logic [2:0][QUO_W-1:0]        sat;
  logic [2:0][NORMAL_WIDTH-1:0] comp;
  lane_t                        lane_last;

  assign lane_last = lane[QUO_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i]  = (quo[QUO_W-1][i] > QMAX) ? QMAX : quo[QUO_W-1][i];
      comp[i] = lane_last.degen  ? '0 :
                lane_last.neg[i] ? NORMAL_WIDTH'(-sat[i]) : NORMAL_WIDTH'(sat[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QUO_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.normal_x   <= comp[0];
      out_word.normal_y   <= comp[1];
      out_word.normal_z   <= comp[2];
      out_word.degenerate <= lane_last.degen;
    end
  end

endmodule

// File: design/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle: edges, cross product, square root of the
// squared length and a rounded divide, as one deep pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  tri     | in        | tri_valid / tri_stall   | tri_word_t  (vertices A, B, C)
//  norm    | out       | norm_valid / norm_stall | norm_word_t (normal, degenerate)
//
//  One triangle enters per cycle while tri_stall is low; the pipeline runs
//  through a 32-stage square root and a divider with 16 quotient stages.
//  Reset (rst, synchronous) clears every valid bit and the skid full bit.
//  A stall on norm parks one word in a skid register; tri_stall is that
//  register's full bit, so the whole pipeline holds while it is set.
// ----------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tri_valid,
  output logic       tri_stall,
  input  tri_word_t  tri_word,
  output logic       norm_valid,
  input  logic       norm_stall,
  output norm_word_t norm_word
);

  logic              en;
  logic              cross_valid, scale_valid, root_valid, div_valid;
  cross_t            cross_prod;
  logic [SUM_W-1:0]  sum;
  lane_t             scale_lane, root_lane;
  logic [ROOT_W-1:0] root;
  norm_word_t        div_word;
  logic              skid_full;
  norm_word_t        skid;

  assign en        = !skid_full;
  assign tri_stall = skid_full;

  tfn_cross u_cross (
    .clk, .rst, .en,
    .in_valid (tri_valid),
    .in_word  (tri_word),
    .out_valid(cross_valid),
    .out_cross(cross_prod)
  );

  tfn_scale u_scale (
    .clk, .rst, .en,
    .in_valid (cross_valid),
    .in_cross (cross_prod),
    .out_valid(scale_valid),
    .out_sum  (sum),
    .out_lane (scale_lane)
  );

  tfn_isqrt u_isqrt (
    .clk, .rst, .en,
    .in_valid (scale_valid),
    .in_sum   (sum),
    .in_lane  (scale_lane),
    .out_valid(root_valid),
    .out_root (root),
    .out_lane (root_lane)
  );

  tfn_div u_div (
    .clk, .rst, .en,
    .in_valid (root_valid),
    .in_root  (root),
    .in_lane  (root_lane),
    .out_valid(div_valid),
    .out_word (div_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_valid <= 1'b0;
      skid_full  <= 1'b0;
    end else if (!norm_valid || !norm_stall) begin
      if (skid_full) begin
        norm_valid <= 1'b1;
        skid_full  <= 1'b0;
      end else begin
        norm_valid <= div_valid;
      end
    end else if (div_valid && en) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!norm_valid || !norm_stall) begin
      norm_word <= skid_full ? skid : div_word;
    end else if (div_valid && en) begin
      skid <= div_word;
    end
  end

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> norm_valid)
    else $error("skid holds a word while output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_full && !norm_stall) |=> (!skid_full && norm_valid))
    else $error("skid word not moved to output");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (norm_valid && norm_word.degenerate) |->
      (norm_word.normal_x == '0 && norm_word.normal_y == '0 &&
       norm_word.normal_z == '0))
    else $error("degenerate word with nonzero normal");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    norm_valid |->
      (norm_word.normal_x != {1'b1, {(NORMAL_WIDTH-1){1'b0}}} &&
       norm_word.normal_y != {1'b1, {(NORMAL_WIDTH-1){1'b0}}} &&
       norm_word.normal_z != {1'b1, {(NORMAL_WIDTH-1){1'b0}}}))
    else $error("normal component outside saturation range");

endmodule

// File: bench/triangle_face_normal_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// Drives triangles through the face normal pipeline with random gaps and
// stalls on both channels. Each normal word is checked against a local
// computation of the exact cross product, its reduction, root and divide.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;
  import tfn_pkg::*;

  localparam int LATENCY = 58;
  localparam int N_RANDOM = 600;
  localparam int N_DIRECTED = 14;

  logic       clk;
  logic       rst;
  logic       tri_valid;
  logic       tri_stall;
  tri_word_t  tri_word;
  logic       norm_valid;
  logic       norm_stall;
  norm_word_t norm_word;

  norm_word_t pending_normals[$];
  int errors;
  int words_checked;
  int degen_seen;
  int sat_seen;
  bit sending_done;

  triangle_face_normal i_dut (
    .clk       (clk),
    .rst       (rst),
    .tri_valid (tri_valid),
    .tri_stall (tri_stall),
    .tri_word  (tri_word),
    .norm_valid(norm_valid),
    .norm_stall(norm_stall),
    .norm_word (norm_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Exact cross product, reduce to 31 bits, floor root, round-half-up divide.
  function automatic norm_word_t face_normal(input tri_word_t t);
    norm_word_t       n;
    logic signed [127:0] a[3], b[3], c[3], e1[3], e2[3], cr[3];
    logic [127:0]     mag[3];
    logic [63:0]      red[3];
    logic [63:0]      sum, root, rem, bitv, q, qmax;
    int               maxlen, s;
    a[0] = t.vertex_a_x; a[1] = t.vertex_a_y; a[2] = t.vertex_a_z;
    b[0] = t.vertex_b_x; b[1] = t.vertex_b_y; b[2] = t.vertex_b_z;
    c[0] = t.vertex_c_x; c[1] = t.vertex_c_y; c[2] = t.vertex_c_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    maxlen = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int k = 0; k < 128; k++) if (mag[i][k] && k + 1 > maxlen) maxlen = k + 1;
    end
    n = '0;
    if (maxlen == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    s = maxlen > 31 ? maxlen - 31 : 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      red[i] = 64'(mag[i] >> s);
      sum += red[i] * red[i];
    end
    root = 0;
    rem = sum;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    qmax = (64'd1 << (NORMAL_WIDTH - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      q = ((red[i] << NORMAL_WIDTH) + root) / (2 * root);
      if (q > qmax) q = qmax;
      if (cr[i] < 0) q = -q;
      if (i == 0) n.normal_x = q[NORMAL_WIDTH-1:0];
      if (i == 1) n.normal_y = q[NORMAL_WIDTH-1:0];
      if (i == 2) n.normal_z = q[NORMAL_WIDTH-1:0];
    end
    return n;
  endfunction

  function automatic tri_word_t make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
    tri_word_t t;
    t = '{24'(ax), 24'(ay), 24'(az), 24'(bx), 24'(by), 24'(bz), 24'(cx), 24'(cy), 24'(cz)};
    return t;
  endfunction

  function automatic logic signed [23:0] rand_coord(input int span);
    logic signed [23:0] v;
    case ($urandom_range(3))
      0: v = 24'($urandom);
      1: v = $urandom_range(1) ? 24'sh7fffff - 24'($urandom_range(span)) :
                                 24'sh800000 + 24'($urandom_range(span));
      default: v = 24'(int'($urandom_range(2 * span)) - span);
    endcase
    return v;
  endfunction

  function automatic tri_word_t random_tri();
    tri_word_t t;
    int span;
    span = $urandom_range(2) == 0 ? 4 : ($urandom_range(1) ? 1000 : 8388607);
    t = {9{24'h0}};
    t.vertex_a_x = rand_coord(span); t.vertex_a_y = rand_coord(span);
    t.vertex_a_z = rand_coord(span); t.vertex_b_x = rand_coord(span);
    t.vertex_b_y = rand_coord(span); t.vertex_b_z = rand_coord(span);
    t.vertex_c_x = rand_coord(span); t.vertex_c_y = rand_coord(span);
    t.vertex_c_z = rand_coord(span);
    // occasionally share one x coordinate, or collapse to a line
    case ($urandom_range(11))
      0: t.vertex_c_x = t.vertex_a_x;
      1: begin
        t.vertex_b_x = t.vertex_a_x; t.vertex_b_y = t.vertex_a_y;
        t.vertex_b_z = t.vertex_a_z;
      end
      2: begin
        t.vertex_c_x = t.vertex_b_x; t.vertex_c_y = t.vertex_b_y;
        t.vertex_c_z = t.vertex_b_z;
      end
      default: ;
    endcase
    return t;
  endfunction

  // drop valid only for a real gap, so back-to-back words keep it high
  task automatic send_word(input tri_word_t t);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
    if (gap != 0) begin
      tri_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tri_valid <= 1'b1;
    tri_word  <= t;
    @(posedge clk);
    while (tri_stall) @(posedge clk);
    pending_normals.push_back(face_normal(t));
  endtask

  // directed rows: vertices plus a typed-in expected word where obvious
  tri_word_t  dir_tri[N_DIRECTED];
  norm_word_t dir_exp[N_DIRECTED];
  bit         dir_has_exp[N_DIRECTED];

  initial begin
    dir_tri[0]  = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tri[1]  = make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
    dir_tri[2]  = make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
    dir_tri[3]  = make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    dir_tri[4]  = make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    dir_tri[5]  = make_tri(5, 5, 5, 5, 5, 5, 9, 9, 9);
    dir_tri[6]  = make_tri(-8388608, -8388608, -8388608, -8388608, -8388608,
                           -8388608, -8388608, -8388608, -8388608);
    dir_tri[7]  = make_tri(-8388608, -8388608, -8388608, 8388607, -8388608,
                           -8388608, -8388608, 8388607, -8388608);
    dir_tri[8]  = make_tri(8388607, 8388607, 8388607, -8388608, 8388607,
                           8388607, 8388607, -8388608, 8388607);
    dir_tri[9]  = make_tri(-8388608, 8388607, -8388608, 8388607, -8388608,
                           8388607, -8388608, -8388608, 8388607);
    dir_tri[10] = make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9);
    dir_tri[11] = make_tri(0, 0, 0, 1, 1, 0, -1, 1, 1);
    dir_tri[12] = make_tri(8388607, -8388608, 0, 0, 8388607, -8388608,
                           -8388608, 0, 8388607);
    dir_tri[13] = make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0);
    for (int i = 0; i < N_DIRECTED; i++) dir_has_exp[i] = 1'b0;
    dir_exp[0] = '{16'sd0, 16'sd0, 16'sd0, 1'b1}; dir_has_exp[0] = 1'b1;
    dir_exp[1] = '{16'sd0, 16'sd0, 16'sd32767, 1'b0}; dir_has_exp[1] = 1'b1;
    dir_exp[2] = '{16'sd0, 16'sd0, -16'sd32767, 1'b0}; dir_has_exp[2] = 1'b1;
    dir_exp[3] = '{16'sd32767, 16'sd0, 16'sd0, 1'b0}; dir_has_exp[3] = 1'b1;
    dir_exp[4] = '{16'sd0, 16'sd32767, 16'sd0, 1'b0}; dir_has_exp[4] = 1'b1;
    dir_exp[5] = '{16'sd0, 16'sd0, 16'sd0, 1'b1}; dir_has_exp[5] = 1'b1;
    dir_exp[6] = '{16'sd0, 16'sd0, 16'sd0, 1'b1}; dir_has_exp[6] = 1'b1;
    dir_exp[7] = '{16'sd0, 16'sd0, 16'sd32767, 1'b0}; dir_has_exp[7] = 1'b1;
    dir_exp[8] = '{16'sd0, 16'sd0, 16'sd32767, 1'b0}; dir_has_exp[8] = 1'b1;
    dir_exp[10] = '{16'sd0, 16'sd0, 16'sd0, 1'b1}; dir_has_exp[10] = 1'b1;
    dir_exp[13] = '{16'sd0, 16'sd0, 16'sd32767, 1'b0}; dir_has_exp[13] = 1'b1;
  end

  // stimulus
  initial begin
    int wait_cycles;
    rst          = 1'b1;
    tri_valid    = 1'b0;
    tri_word     = '0;
    sending_done = 1'b0;
    errors       = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_has_exp[i] && face_normal(dir_tri[i]) !== dir_exp[i]) begin
        $display("%0t: table row %0d expected %h predicted %h", $time, i,
                 dir_exp[i], face_normal(dir_tri[i]));
        errors++;
      end
      send_word(dir_tri[i]);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      // drain the pipeline now and then
      if (i == N_RANDOM / 2 || $urandom_range(150) == 0) begin
        tri_valid <= 1'b0;
        @(posedge clk);
        while (pending_normals.size() != 0) @(posedge clk);
      end
      if (i % 100 < 30) begin
        // back-to-back burst
        tri_valid <= 1'b1;
        tri_word  <= random_tri();
        @(posedge clk);
        while (tri_stall) @(posedge clk);
        pending_normals.push_back(face_normal(tri_word));
      end else begin
        send_word(random_tri());
      end
    end
    tri_valid <= 1'b0;
    sending_done = 1'b1;
    wait_cycles = 0;
    while (pending_normals.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d normal words (%0d degenerate, %0d with a saturated axis)",
             words_checked, degen_seen, sat_seen);
    $display("over %0d directed and %0d random triangles with random gaps and stalls.",
             N_DIRECTED, N_RANDOM);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (pending_normals.size() != 0)
        $display("%0t: %0d normal words never arrived", $time, pending_normals.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: random stall per word, with calm stretches
  initial begin
    int hold;
    norm_stall = 1'b1;
    words_checked = 0;
    degen_seen = 0;
    sat_seen = 0;
    @(negedge rst);
    forever begin
      hold = ($urandom_range(255) < 64) ? 0 : $urandom_range(6);
      if (hold != 0) begin
        norm_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      norm_stall <= 1'b0;
      @(posedge clk);
      while (!norm_valid) @(posedge clk);
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected word %h", $time, norm_word);
        errors++;
      end else begin
        norm_word_t want;
        want = pending_normals.pop_front();
        words_checked++;
        if (want.degenerate) degen_seen++;
        if (want.normal_x == 16'sd32767 || want.normal_y == 16'sd32767 ||
            want.normal_z == 16'sd32767 || want.normal_x == -16'sd32767 ||
            want.normal_y == -16'sd32767 || want.normal_z == -16'sd32767)
          sat_seen++;
        if (norm_word.normal_x !== want.normal_x)
          $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x,
                   norm_word.normal_x);
        if (norm_word.normal_y !== want.normal_y)
          $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y,
                   norm_word.normal_y);
        if (norm_word.normal_z !== want.normal_z)
          $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z,
                   norm_word.normal_z);
        if (norm_word.degenerate !== want.degenerate)
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                   norm_word.degenerate);
        if (norm_word !== want) errors++;
      end
    end
  end

endmodule
